// ===== rtl/ffsa_pkg.sv =====
// Package for the first-fit segment allocator.
// Holds shared types, status codes, operation codes and controller states.
package ffsa_pkg;

  localparam int MaxSegments = 64;
  localparam int AddrBits    = 16;
  localparam int PoolReset   = 4096;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_SPLIT_FIN,
    S_SPLIT_TAKE,
    S_FREE_MARK,
    S_MRG_RD,
    S_MRG_CHK,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load_req;    // capture item fields
    logic       init_table;  // write one free segment at entry 0
    logic       clr_idx;     // index to zero
    logic       inc_idx;     // index plus one
    logic       rd_idx;      // read entry at index
    logic       rd_idx1;     // read entry at index plus one
    logic       rd_prev;     // read entry at shift pointer minus one
    logic       set_shift;   // shift pointer to count
    logic       dec_shift;   // shift pointer minus one
    logic       wr_shift;    // write held entry to shift pointer
    logic       wr_split;    // write taken entry at index
    logic       wr_rem;      // write split remainder at index plus one
    logic       mark_free;   // mark entry at index free
    logic       wr_merge;    // write merged entry at index
    logic       start_rm;    // shift pointer to index plus two
    logic       wr_rm;       // write held entry at shift pointer minus one
    logic       inc_rm;      // shift pointer plus one
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_result;
    status_t    res_status;
    logic       res_grant;   // grant start of entry at index
  } ffsa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic op_free;
    logic size_zero;
    logic idx_end;       // index has reached count
    logic idx1_end;      // index plus one has reached count
    logic fit;           // read entry is free and long enough
    logic exact;         // read entry length equals request
    logic full;          // count at capacity
    logic match;         // read entry starts at address and is allocated
    logic both_free;     // entries index and index plus one both free
    logic shift_done;    // shift pointer has reached index plus one
    logic rm_done;       // remove sweep reached count
  } ffsa_sts_t;

endpackage

// ===== rtl/first_fit_segment_allocator_top.sv =====
// First-fit segment allocator with coalescing. One item gives one result,
// shown for one cycle with done high; the receiver cannot stall it. An item
// searches the segments in order; a split moves entries up, then writes the
// remainder and the taken entry; a free marks the entry, then checks each
// adjacent pair and moves entries down after each merge.
// Writing pool_size reinitializes the table; a configuration write is taken
// only while idle and no item is offered on start.
module first_fit_segment_allocator_top #(
  parameter int MaxSegments = ffsa_pkg::MaxSegments,
  parameter int AddrBits    = ffsa_pkg::AddrBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                operation,
  input  logic [AddrBits-1:0] request_size,
  input  logic [AddrBits-1:0] release_address,
  output logic                done,
  output logic [1:0]          status,
  output logic [AddrBits-1:0] granted_address,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [AddrBits-1:0] cfg_data
);
  ffsa_pkg::ffsa_cmd_t cmd;
  ffsa_pkg::ffsa_sts_t sts;
  logic ctrl_busy, done_q;

  // Accept configuration only when idle and no item is offered.
  assign cfg_ready = !ctrl_busy && !start;
  assign busy = ctrl_busy;

  // Raise done for one cycle after the result is set.
  always_ff @(posedge clk) begin
    if (rst) done_q <= 1'b0;
    else done_q <= cmd.set_result;
  end
  assign done = done_q;

  ffsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_write(cfg_valid & cfg_ready),
    .sts(sts), .cmd(cmd), .busy(ctrl_busy)
  );

  ffsa_dpath #(.MaxSegments(MaxSegments), .AddrBits(AddrBits)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_write(cfg_valid & cfg_ready), .cfg_data(cfg_data),
    .operation(operation), .request_size(request_size),
    .release_address(release_address), .status(status),
    .granted_address(granted_address)
  );
endmodule

// ===== rtl/ffsa_ram.sv =====
// Generic RAM with one write port and one registered read port.
// No dependencies.
module ffsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ffsa_ctrl.sv =====
// Controller for the first-fit segment allocator.
// Uses ffsa_pkg states, command and status structs.
module ffsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cfg_write,
  input  ffsa_pkg::ffsa_sts_t sts,
  output ffsa_pkg::ffsa_cmd_t cmd,
  output logic               busy
);
  ffsa_pkg::state_t state, state_next;

  // Hold the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffsa_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_status = ffsa_pkg::ST_OK;
    busy = (state != ffsa_pkg::S_IDLE);
    unique case (state)
      ffsa_pkg::S_IDLE: begin
        if (cfg_write) begin
          state_next = ffsa_pkg::S_INIT;
        end else if (start) begin
          cmd.load_req = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next = ffsa_pkg::S_SRCH_RD;
        end
      end
      ffsa_pkg::S_INIT: begin
        cmd.init_table = 1'b1;
        state_next = ffsa_pkg::S_IDLE;
      end
      ffsa_pkg::S_SRCH_RD: begin
        priority if (!sts.op_free && sts.size_zero) begin
          cmd.set_result = 1'b1;
          cmd.res_status = ffsa_pkg::ST_NOFIT;
          state_next = ffsa_pkg::S_DONE;
        end else if (sts.idx_end) begin
          cmd.set_result = 1'b1;
          cmd.res_status = sts.op_free ? ffsa_pkg::ST_BADFREE : ffsa_pkg::ST_NOFIT;
          state_next = ffsa_pkg::S_DONE;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = ffsa_pkg::S_SRCH_CHK;
        end
      end
      ffsa_pkg::S_SRCH_CHK: begin
        priority if (sts.op_free) begin
          if (sts.match) begin
            cmd.mark_free = 1'b1;
            state_next = ffsa_pkg::S_FREE_MARK;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next = ffsa_pkg::S_SRCH_RD;
          end
        end else if (!sts.fit) begin
          cmd.inc_idx = 1'b1;
          state_next = ffsa_pkg::S_SRCH_RD;
        end else if (sts.exact) begin
          cmd.mark_free = 1'b0;
          cmd.wr_split = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_grant = 1'b1;
          state_next = ffsa_pkg::S_DONE;
        end else if (sts.full) begin
          cmd.set_result = 1'b1;
          cmd.res_status = ffsa_pkg::ST_FULL;
          state_next = ffsa_pkg::S_DONE;
        end else begin
          cmd.set_shift = 1'b1;
          state_next = ffsa_pkg::S_SPLIT_RD;
        end
      end
      ffsa_pkg::S_SPLIT_RD: begin
        if (sts.shift_done) begin
          cmd.rd_idx = 1'b1;
          state_next = ffsa_pkg::S_SPLIT_FIN;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next = ffsa_pkg::S_SPLIT_WR;
        end
      end
      ffsa_pkg::S_SPLIT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.dec_shift = 1'b1;
        state_next = ffsa_pkg::S_SPLIT_RD;
      end
      // Write the remainder first and keep the taken entry on the read port.
      ffsa_pkg::S_SPLIT_FIN: begin
        cmd.wr_rem = 1'b1;
        cmd.rd_idx = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next = ffsa_pkg::S_SPLIT_TAKE;
      end
      ffsa_pkg::S_SPLIT_TAKE: begin
        cmd.wr_split = 1'b1;
        cmd.set_result = 1'b1;
        cmd.res_grant = 1'b1;
        state_next = ffsa_pkg::S_DONE;
      end
      ffsa_pkg::S_FREE_MARK: begin
        cmd.clr_idx = 1'b1;
        state_next = ffsa_pkg::S_MRG_RD;
      end
      ffsa_pkg::S_MRG_RD: begin
        if (sts.idx1_end) begin
          cmd.set_result = 1'b1;
          state_next = ffsa_pkg::S_DONE;
        end else begin
          cmd.rd_idx = 1'b1;
          cmd.rd_idx1 = 1'b1;
          state_next = ffsa_pkg::S_MRG_CHK;
        end
      end
      ffsa_pkg::S_MRG_CHK: begin
        if (sts.both_free) begin
          cmd.wr_merge = 1'b1;
          cmd.start_rm = 1'b1;
          state_next = ffsa_pkg::S_SH_RD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next = ffsa_pkg::S_MRG_RD;
        end
      end
      ffsa_pkg::S_SH_RD: begin
        if (sts.rm_done) begin
          cmd.cnt_dec = 1'b1;
          state_next = ffsa_pkg::S_MRG_RD;
        end else begin
          cmd.rd_idx = 1'b0;
          state_next = ffsa_pkg::S_SH_WR;
        end
      end
      ffsa_pkg::S_SH_WR: begin
        cmd.wr_rm = 1'b1;
        cmd.inc_rm = 1'b1;
        state_next = ffsa_pkg::S_SH_RD;
      end
      ffsa_pkg::S_DONE: begin
        state_next = ffsa_pkg::S_IDLE;
      end
      default: begin
        state_next = ffsa_pkg::S_IDLE;
      end
    endcase
  end
endmodule

// ===== rtl/ffsa_dpath.sv =====
// Datapath for the first-fit segment allocator: segment table RAM,
// index and shift pointers, request and result registers. Uses ffsa_pkg, ffsa_ram.
module ffsa_dpath #(
  parameter int MaxSegments = ffsa_pkg::MaxSegments,
  parameter int AddrBits    = ffsa_pkg::AddrBits
) (
  input  logic                clk,
  input  logic                rst,
  input  ffsa_pkg::ffsa_cmd_t cmd,
  output ffsa_pkg::ffsa_sts_t sts,
  input  logic                cfg_write,
  input  logic [AddrBits-1:0] cfg_data,
  input  logic                operation,
  input  logic [AddrBits-1:0] request_size,
  input  logic [AddrBits-1:0] release_address,
  output logic [1:0]          status,
  output logic [AddrBits-1:0] granted_address
);
  localparam int IdxBits = $clog2(MaxSegments);
  localparam int CntBits = $clog2(MaxSegments + 1);
  localparam int EntBits = 2 * AddrBits + 1;

  logic [AddrBits-1:0] pool_size, req_size, req_addr;
  logic                req_op;
  logic [CntBits-1:0]  count, idx, shp;
  logic [EntBits-1:0]  rd_a, rd_b, wdata_a, wdata_b;
  logic [IdxBits-1:0]  raddr_a, raddr_b, waddr_a, waddr_b;
  logic                we_a, we_b;
  logic                spl_pend;
  logic [AddrBits-1:0] a_start, a_len, b_start, b_len;
  logic                a_free, b_free;
  logic [CntBits-1:0]  idx1;
  logic [AddrBits-1:0] cfg_pool;

  assign cfg_pool = AddrBits'(cfg_data);
  assign idx1 = idx + CntBits'(1);
  assign {a_start, a_len, a_free} = rd_a;
  assign {b_start, b_len, b_free} = rd_b;

  // Hold pool size, segment count and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= AddrBits'(ffsa_pkg::PoolReset);
      count <= CntBits'(1);
      idx <= '0;
      shp <= '0;
      spl_pend <= 1'b0;
    end else begin
      if (cfg_write) pool_size <= cfg_pool;
      if (cmd.init_table) count <= CntBits'(1);
      else if (cmd.cnt_inc) count <= count + CntBits'(1);
      else if (cmd.cnt_dec) count <= count - CntBits'(1);
      if (cmd.clr_idx) idx <= '0;
      else if (cmd.inc_idx) idx <= idx1;
      if (cmd.set_shift) shp <= count;
      else if (cmd.dec_shift) shp <= shp - CntBits'(1);
      else if (cmd.start_rm) shp <= idx + CntBits'(2);
      else if (cmd.inc_rm) shp <= shp + CntBits'(1);
      spl_pend <= cmd.rd_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op <= operation;
      req_size <= AddrBits'(request_size);
      req_addr <= AddrBits'(release_address);
    end
    if (cmd.set_result) begin
      status <= cmd.res_status;
      granted_address <= cmd.res_grant ? a_start : '0;
    end
  end

  // Select RAM addresses: port a reads index or sweep source, port b index plus one.
  always_comb begin
    raddr_a = idx[IdxBits-1:0];
    if (cmd.rd_prev) raddr_a = IdxBits'(shp - CntBits'(1));
    else if (!cmd.rd_idx && !cmd.rd_idx1) raddr_a = shp[IdxBits-1:0];
    raddr_b = idx1[IdxBits-1:0];
    we_a = 1'b0;
    we_b = 1'b0;
    waddr_a = idx[IdxBits-1:0];
    waddr_b = idx1[IdxBits-1:0];
    wdata_a = rd_a;
    wdata_b = rd_a;
    if (cmd.init_table) begin
      we_a = 1'b1;
      waddr_a = '0;
      wdata_a = {AddrBits'(0), pool_size, 1'b1};
    end else if (cmd.wr_shift) begin
      we_a = 1'b1;
      waddr_a = shp[IdxBits-1:0];
    end else if (cmd.wr_split) begin
      we_a = 1'b1;
      wdata_a = {a_start, req_size, 1'b0};
    end else if (cmd.wr_rem) begin
      we_b = 1'b1;
      wdata_b = {a_start + req_size, a_len - req_size, 1'b1};
    end else if (cmd.mark_free) begin
      we_a = 1'b1;
      wdata_a = {a_start, a_len, 1'b1};
    end else if (cmd.wr_merge) begin
      we_a = 1'b1;
      wdata_a = {a_start, a_len + b_len, 1'b1};
    end else if (cmd.wr_rm) begin
      we_a = 1'b1;
      waddr_a = IdxBits'(shp - CntBits'(1));
    end
  end

  // One RAM for the main port, a mirror for the second read port.
  ffsa_ram #(.Width(EntBits), .Depth(MaxSegments)) u_ram_a (
    .clk(clk), .we(we_a | we_b), .waddr(we_a ? waddr_a : waddr_b),
    .wdata(we_a ? wdata_a : wdata_b), .raddr(raddr_a), .rdata(rd_a)
  );
  ffsa_ram #(.Width(EntBits), .Depth(MaxSegments)) u_ram_b (
    .clk(clk), .we(we_a | we_b), .waddr(we_a ? waddr_a : waddr_b),
    .wdata(we_a ? wdata_a : wdata_b), .raddr(raddr_b), .rdata(rd_b)
  );

  // Report status to the controller.
  always_comb begin
    sts.op_free = (req_op == ffsa_pkg::OP_FREE);
    sts.size_zero = (req_size == '0);
    sts.idx_end = (idx >= count);
    sts.idx1_end = (idx1 >= count);
    sts.fit = a_free && (a_len >= req_size);
    sts.exact = (a_len == req_size);
    sts.full = (count >= CntBits'(MaxSegments));
    sts.match = (a_start == req_addr) && !a_free;
    sts.both_free = a_free && b_free;
    sts.shift_done = (shp <= idx1) && !spl_pend;
    sts.rm_done = (shp >= count);
  end
endmodule

// ===== rtl/ffsa_checker.sv =====
// Port-level checks for the first-fit segment allocator.
// Bound to first_fit_segment_allocator_top.
module ffsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [15:0] granted_address,
  input logic        cfg_ready
);
  // Accepted item keeps the block busy next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("not busy after accept");
  // Result strobe is a single pulse.
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  // Failed result grants nothing.
  a_grant: assert property (@(posedge clk) disable iff (rst)
    (done && status != ffsa_pkg::ST_OK) |-> (granted_address == 16'd0))
    else $error("grant on fail");
  // Config ready only when idle.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("cfg while busy");
endmodule

bind first_fit_segment_allocator_top ffsa_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .granted_address(granted_address), .cfg_ready(cfg_ready)
);

// ===== dv/tb.sv =====
// Self-checking bench for first_fit_segment_allocator_top.
// Holds a scoreboard with its own first-fit table and drives the block by tasks;
// depends on ffsa_pkg and the allocator RTL.
module tb;

  localparam int SegCap  = ffsa_pkg::MaxSegments;
  localparam int IdleCap = 20000;

  class alloc_scoreboard;
    logic [15:0]       pool;
    logic [15:0]       seg_base[SegCap];
    logic [15:0]       seg_len[SegCap];
    bit                seg_free[SegCap];
    int                seg_cnt;
    ffsa_pkg::status_t want_status[$];
    logic [15:0]       want_addr[$];
    int                mismatches;

    // Rebuild the table as one free segment covering the pool.
    function void load_pool(logic [15:0] p);
      pool = p;
      seg_base[0] = '0;
      seg_len[0] = p;
      seg_free[0] = 1'b1;
      seg_cnt = 1;
    endfunction

    function void drop_entry(int idx);
      for (int k = idx; k + 1 < seg_cnt; k++) begin
        seg_base[k] = seg_base[k+1];
        seg_len[k] = seg_len[k+1];
        seg_free[k] = seg_free[k+1];
      end
      seg_cnt--;
    endfunction

    // Predict one accepted item and push its expected result.
    function void note_item(logic op, logic [15:0] sz, logic [15:0] addr);
      ffsa_pkg::status_t st;
      logic [15:0]       ga;
      int                i;
      bit                hit;
      st = ffsa_pkg::ST_NOFIT;
      ga = '0;
      hit = 1'b0;
      if (op == ffsa_pkg::OP_ALLOC) begin
        if (sz != 0) begin
          for (i = 0; i < seg_cnt && !hit; i++) begin
            if (seg_free[i] && seg_len[i] >= sz) begin
              hit = 1'b1;
              if (seg_len[i] > sz && seg_cnt >= SegCap) begin
                st = ffsa_pkg::ST_FULL;
              end else begin
                if (seg_len[i] > sz) begin
                  for (int k = seg_cnt; k > i + 1; k--) begin
                    seg_base[k] = seg_base[k-1];
                    seg_len[k] = seg_len[k-1];
                    seg_free[k] = seg_free[k-1];
                  end
                  seg_base[i+1] = seg_base[i] + sz;
                  seg_len[i+1] = seg_len[i] - sz;
                  seg_free[i+1] = 1'b1;
                  seg_len[i] = sz;
                  seg_cnt++;
                end
                seg_free[i] = 1'b0;
                ga = seg_base[i];
                st = ffsa_pkg::ST_OK;
              end
            end
          end
        end
      end else begin
        st = ffsa_pkg::ST_BADFREE;
        for (i = 0; i < seg_cnt && !hit; i++) begin
          if (seg_base[i] == addr && !seg_free[i]) begin
            hit = 1'b1;
            seg_free[i] = 1'b1;
            st = ffsa_pkg::ST_OK;
          end
        end
        // Coalesce adjacent free runs.
        i = 0;
        while (hit && i + 1 < seg_cnt) begin
          if (seg_free[i] && seg_free[i+1]) begin
            seg_len[i] = seg_len[i] + seg_len[i+1];
            drop_entry(i + 1);
          end else begin
            i++;
          end
        end
      end
      want_status.push_back(st);
      want_addr.push_back(ga);
    endfunction

    // Compare one result against the oldest expectation.
    function void check_result(logic [1:0] st, logic [15:0] ga);
      if (want_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d addr=%0d", st, ga);
        return;
      end
      if (st !== want_status[0] || ga !== want_addr[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status=%0d addr=%0d, got status=%0d addr=%0d",
                   want_status[0], want_addr[0], st, ga);
      end
      void'(want_status.pop_front());
      void'(want_addr.pop_front());
    endfunction

    // Pick a start address of a currently allocated segment, if any.
    function logic [15:0] pick_used();
      int idx[$];
      for (int k = 0; k < seg_cnt; k++) if (!seg_free[k]) idx.push_back(k);
      if (idx.size() == 0) return 16'($urandom());
      return seg_base[idx[$urandom_range(idx.size() - 1)]];
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        operation;
  logic [15:0] request_size;
  logic [15:0] release_address;
  logic        done;
  logic [1:0]  status;
  logic [15:0] granted_address;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  alloc_scoreboard sb;
  int  idle_cycles;
  bit  timed_out;

  first_fit_segment_allocator_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .request_size(request_size),
    .release_address(release_address), .done(done), .status(status),
    .granted_address(granted_address), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Check results and watch for a stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, granted_address);
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleCap && !timed_out) begin
        timed_out = 1'b1;
        $display("tb failed");
        $finish;
      end
    end
  end

  // Hand one item to the block; the model is updated at acceptance.
  task automatic send_item(logic op, logic [15:0] sz, logic [15:0] addr);
    start <= 1'b1;
    operation <= op;
    request_size <= sz;
    release_address <= addr;
    do @(posedge clk); while (busy);
    sb.note_item(op, sz, addr);
    start <= 1'b0;
    // The block is busy on the next cycle anyway.
    @(posedge clk);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(3) == 0 ? $urandom_range(1, 8) : 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.want_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool(logic [15:0] p);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= p;
    do @(posedge clk); while (!cfg_ready);
    sb.load_pool(p);
    cfg_valid <= 1'b0;
  endtask

  // Random phase: mostly allocs and frees of live segments, some noise.
  task automatic random_phase(int n, int max_sz);
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      int r;
      r = $urandom_range(99);
      if (r < 50) begin
        send_item(ffsa_pkg::OP_ALLOC, 16'($urandom_range(max_sz)), 16'($urandom()));
      end else if (r < 88) begin
        send_item(ffsa_pkg::OP_FREE, 16'($urandom()), sb.pick_used());
      end else if (r < 94) begin
        send_item(ffsa_pkg::OP_ALLOC, 16'($urandom()), 16'($urandom()));
      end else begin
        send_item(ffsa_pkg::OP_FREE, 16'($urandom()), 16'($urandom()));
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        gap();
      end else begin
        burst--;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.load_pool(16'(ffsa_pkg::PoolReset));
    rst = 1'b1;
    start = 1'b0;
    operation = ffsa_pkg::OP_ALLOC;
    request_size = '0;
    release_address = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_cycles = 0;
    timed_out = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero size, no fit, bad frees, merge.
    send_item(ffsa_pkg::OP_ALLOC, 16'd0, 16'd0);
    send_item(ffsa_pkg::OP_ALLOC, 16'd100, 16'hFFFF);
    send_item(ffsa_pkg::OP_ALLOC, 16'd200, 16'd0);
    send_item(ffsa_pkg::OP_ALLOC, 16'hFFFF, 16'd0);
    send_item(ffsa_pkg::OP_FREE, 16'd0, 16'd100);
    send_item(ffsa_pkg::OP_FREE, 16'hFFFF, 16'd50);
    send_item(ffsa_pkg::OP_FREE, 16'd0, 16'd0);
    send_item(ffsa_pkg::OP_FREE, 16'd0, 16'd0);
    send_item(ffsa_pkg::OP_ALLOC, 16'd3796, 16'd0);
    send_item(ffsa_pkg::OP_ALLOC, 16'd1, 16'd0);
    // Fill the table with unit segments to reach the full case.
    write_pool(16'hFFFF);
    for (int k = 0; k < 64; k++) send_item(ffsa_pkg::OP_ALLOC, 16'd1, 16'd0);
    send_item(ffsa_pkg::OP_FREE, 16'd0, 16'd10);
    send_item(ffsa_pkg::OP_ALLOC, 16'd1, 16'd0);
    send_item(ffsa_pkg::OP_ALLOC, 16'd2, 16'd0);
    write_pool(16'd0);
    send_item(ffsa_pkg::OP_ALLOC, 16'd1, 16'd0);
    send_item(ffsa_pkg::OP_FREE, 16'd0, 16'd0);
    write_pool(16'd1);
    send_item(ffsa_pkg::OP_ALLOC, 16'd1, 16'd0);
    send_item(ffsa_pkg::OP_FREE, 16'd0, 16'd0);

    // Random phases across several pool sizes.
    write_pool(16'd4096);
    random_phase(600, 600);
    write_pool(16'd64);
    random_phase(400, 8);
    write_pool(16'hFFFF);
    random_phase(500, 16'hFFFF);
    write_pool(16'($urandom_range(1, 65535)));
    random_phase(300, 3000);

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.want_status.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ffsa_pkg.sv
rtl/ffsa_ram.sv
rtl/ffsa_ctrl.sv
rtl/ffsa_dpath.sv
rtl/first_fit_segment_allocator_top.sv
rtl/ffsa_checker.sv
dv/tb.sv
